// File: sv/rpg_pkg.sv
package rpg_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;

  // fixed field widths
  localparam int CNT_W     = 13;
  localparam int HL_W      = 16;
  localparam int VEC_W     = 48;
  localparam int COMP_W    = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 3;

  // normalizer widths: components are cut to MAG_BITS before squaring
  localparam int MAG_BITS = 30;
  localparam int SUM_W    = 2 * MAG_BITS + 2;
  localparam int LEN_W    = MAG_BITS + 1;

  // output saturation limits
  localparam int SAT_POS     = 32767;
  localparam int SAT_NEG_MAG = 32768;

  // Q8.8 offset against Q1.14 basis vectors
  localparam int OFF_ALIGN = 14;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;

  // register reset values
  localparam logic [CNT_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CNT_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [HL_W-1:0]  RST_HALF   = 16'd256;
  localparam logic [VEC_W-1:0] RST_UP     = 48'h0000_4000_0000;
  localparam logic [VEC_W-1:0] RST_RIGHT  = 48'h0000_0000_4000;
  localparam logic [VEC_W-1:0] RST_OFFSET = 48'h0100_0000_0000;

  typedef logic [MAG_BITS-1:0] mag_t;

  // data riding along the square root pipe
  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
    logic       degen;
  } rpg_side_t;

  // data riding along the divider pipe
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } rpg_sign_t;

endpackage

// File: sv/pinhole_camera_ray_generator_top.sv
// Pinhole camera primary ray generator.
// Input channel: a pixel word (in_pixel_x, in_pixel_y) is taken at each clock
// edge where start is high and busy is low. busy stays low, so a new pixel
// can be issued every cycle, e.g. a full frame in raster order.
// Result channel: one word per pixel, the unit ray direction out_dir_x/y/z
// (signed, FRAC_BITS fraction bits) and out_degenerate, shown for exactly
// one cycle with out_valid. Results leave in issue order.
// Pipeline: nine arithmetic stages, one square root stage per result bit
// (31), one divider stage per quotient bit (FRAC_BITS + 2) and an output
// register.
// Throughput: one word per cycle.
// Configuration: cfg_we writes register cfg_idx with cfg_wdata;
// write only while no pixel is in flight.
// Reset (synchronous, rst_n low) loads the register defaults (640x480, unit
// half lengths, up = +y, right = +x, offset = +z) and empties the pipe.
// The receiver cannot stall; each result must be taken when shown.
module pinhole_camera_ray_generator_top #(
  parameter int COORD_BITS = rpg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rpg_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_BITS-1:0]             in_pixel_x,
  input  logic [COORD_BITS-1:0]             in_pixel_y,
  input  logic                              cfg_we,
  input  logic [rpg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rpg_pkg::VEC_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic signed [rpg_pkg::OUT_W-1:0]  out_dir_x,
  output logic signed [rpg_pkg::OUT_W-1:0]  out_dir_y,
  output logic signed [rpg_pkg::OUT_W-1:0]  out_dir_z,
  output logic                              out_degenerate
);
  import rpg_pkg::*;

  localparam int NW     = ((COORD_BITS + 1 > CNT_W) ? COORD_BITS + 1 : CNT_W) + 1;
  localparam int A_W    = NW + HL_W + 1;
  localparam int AU_W   = A_W + COMP_W;
  localparam int PW     = AU_W + CNT_W + 1;
  localparam int OFF_W  = COMP_W + 2 * CNT_W + 1;
  localparam int DW     = PW + 2;
  localparam int SW     = $clog2(DW);
  localparam int QB     = FRAC_BITS + 2;

  // configuration registers
  logic [CNT_W-1:0] width_r, height_r;
  logic [HL_W-1:0]  half_x_r, half_y_r;
  logic [VEC_W-1:0] up_r, right_r, offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      half_x_r <= RST_HALF;
      half_y_r <= RST_HALF;
      up_r     <= RST_UP;
      right_r  <= RST_RIGHT;
      offset_r <= RST_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_wdata[CNT_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[CNT_W-1:0];
        REG_HALF_X: half_x_r <= cfg_wdata[HL_W-1:0];
        REG_HALF_Y: half_y_r <= cfg_wdata[HL_W-1:0];
        REG_UP:     up_r     <= cfg_wdata;
        REG_RIGHT:  right_r  <= cfg_wdata;
        REG_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero counts act as one
  logic [CNT_W-1:0] wf, hf;
  assign wf = (width_r == '0) ? CNT_W'(1) : width_r;
  assign hf = (height_r == '0) ? CNT_W'(1) : height_r;

  logic signed [CNT_W:0]  wf_s, hf_s;
  logic signed [HL_W:0]   hx_s, hy_s;
  logic signed [COMP_W-1:0] up_c [3], rt_c [3], off_c [3];

  always_comb begin
    wf_s = $signed({1'b0, wf});
    hf_s = $signed({1'b0, hf});
    hx_s = $signed({1'b0, half_x_r});
    hy_s = $signed({1'b0, half_y_r});
    for (int k = 0; k < 3; k++) begin
      up_c[k]  = $signed(up_r[COMP_W*k +: COMP_W]);
      rt_c[k]  = $signed(right_r[COMP_W*k +: COMP_W]);
      off_c[k] = $signed(offset_r[COMP_W*k +: COMP_W]);
    end
  end

  assign busy = 1'b0;

  // stage 1: centred screen coordinates (2*pixel+1 minus the count), and width*height
  logic                    vld1_r;
  logic signed [NW-1:0]    nx1_r, ny1_r;
  logic [2*CNT_W-1:0]      wh1_r;
  logic signed [NW-1:0]    nx1_nxt, ny1_nxt;

  always_comb begin
    nx1_nxt = $signed(NW'({in_pixel_x, 1'b1})) - $signed(NW'(wf));
    ny1_nxt = $signed(NW'({in_pixel_y, 1'b1})) - $signed(NW'(hf));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    nx1_r <= nx1_nxt;
    ny1_r <= ny1_nxt;
    wh1_r <= wf * hf;
  end

  // stage 2: scale by the half lengths; offset times width*height
  logic                     vld2_r;
  logic signed [A_W-1:0]    ay2_r, ax2_r;
  logic signed [OFF_W-1:0]  off2_r [3];
  logic signed [A_W-1:0]    ay2_nxt, ax2_nxt;
  logic signed [OFF_W-1:0]  off2_nxt [3];
  logic signed [2*CNT_W:0]  wh1_s;

  always_comb begin
    wh1_s   = $signed({1'b0, wh1_r});
    ay2_nxt = ny1_r * hy_s;
    ax2_nxt = nx1_r * hx_s;
    for (int k = 0; k < 3; k++) begin
      off2_nxt[k] = off_c[k] * wh1_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    ay2_r  <= ay2_nxt;
    ax2_r  <= ax2_nxt;
    off2_r <= off2_nxt;
  end

  // stage 3: times the basis vector components
  logic                     vld3_r;
  logic signed [AU_W-1:0]   au3_r [3], br3_r [3];
  logic signed [OFF_W-1:0]  off3_r [3];
  logic signed [AU_W-1:0]   au3_nxt [3], br3_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au3_nxt[k] = ay2_r * up_c[k];
      br3_nxt[k] = ax2_r * rt_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    au3_r  <= au3_nxt;
    br3_r  <= br3_nxt;
    off3_r <= off2_r;
  end

  // stage 4: cross-scale by the other axis count
  logic                     vld4_r;
  logic signed [PW-1:0]     au4_r [3], br4_r [3];
  logic signed [OFF_W-1:0]  off4_r [3];
  logic signed [PW-1:0]     au4_nxt [3], br4_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au4_nxt[k] = au3_r[k] * wf_s;
      br4_nxt[k] = br3_r[k] * hf_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    au4_r  <= au4_nxt;
    br4_r  <= br4_nxt;
    off4_r <= off3_r;
  end

  // stage 5: sum the three terms, split sign and magnitude
  logic               vld5_r;
  logic [DW-1:0]      mag5_r [3];
  logic [2:0]         neg5_r;
  logic signed [DW-1:0] d5 [3], au5_e [3], br5_e [3], off5_e [3];
  logic [DW-1:0]      mag5_nxt [3];
  logic [2:0]         neg5_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au5_e[k]    = au4_r[k];
      br5_e[k]    = br4_r[k];
      off5_e[k]   = off4_r[k];
      d5[k]       = au5_e[k] + br5_e[k] + (off5_e[k] <<< OFF_ALIGN);
      neg5_nxt[k] = d5[k][DW-1];
      mag5_nxt[k] = neg5_nxt[k] ? unsigned'(-d5[k]) : unsigned'(d5[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    mag5_r <= mag5_nxt;
    neg5_r <= neg5_nxt;
  end

  // stage 6: leading one of the largest magnitude sets the shift
  logic           vld6_r;
  logic [DW-1:0]  mag6_r [3];
  logic [2:0]     neg6_r;
  logic           deg6_r;
  logic [SW-1:0]  sh6_r;
  logic [DW-1:0]  or5;
  logic [SW-1:0]  msb5, sh6_nxt;

  always_comb begin
    or5  = mag5_r[0] | mag5_r[1] | mag5_r[2];
    msb5 = '0;
    for (int b = 0; b < DW; b++) begin
      if (or5[b]) msb5 = SW'(b);
    end
    sh6_nxt = (msb5 >= SW'(MAG_BITS)) ? msb5 - SW'(MAG_BITS - 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else begin
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    mag6_r <= mag5_r;
    neg6_r <= neg5_r;
    deg6_r <= (or5 == '0);
    sh6_r  <= sh6_nxt;
  end

  // stage 7: bring magnitudes below 2^MAG_BITS
  logic       vld7_r;
  rpg_side_t  side7_r;
  rpg_side_t  side7_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side7_nxt.mag[k] = MAG_BITS'(mag6_r[k] >> sh6_r);
    end
    side7_nxt.neg   = neg6_r;
    side7_nxt.degen = deg6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else begin
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    side7_r <= side7_nxt;
  end

  // stage 8: squares
  logic                    vld8_r;
  logic [2*MAG_BITS-1:0]   sq8_r [3];
  rpg_side_t               side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld8_r <= 1'b0;
    end else begin
      vld8_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq8_r[k] <= side7_r.mag[k] * side7_r.mag[k];
    end
    side8_r <= side7_r;
  end

  // stage 9: squared length
  logic              vld9_r;
  logic [SUM_W-1:0]  sum9_r;
  rpg_side_t         side9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld9_r <= 1'b0;
    end else begin
      vld9_r <= vld8_r;
    end
  end

  always_ff @(posedge clk) begin
    sum9_r  <= SUM_W'(sq8_r[0]) + SUM_W'(sq8_r[1]) + SUM_W'(sq8_r[2]);
    side9_r <= side8_r;
  end

  // length
  logic              isq_vld;
  logic [LEN_W-1:0]  isq_len;
  rpg_side_t         isq_side;
  rpg_sign_t         isq_sign;

  rpg_isqrt_pipe u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld9_r),
    .in_sum   (sum9_r),
    .in_side  (side9_r),
    .out_vld  (isq_vld),
    .out_len  (isq_len),
    .out_side (isq_side)
  );

  assign isq_sign.neg   = isq_side.neg;
  assign isq_sign.degen = isq_side.degen;

  // per-component rounded quotient
  logic                   div_vld;
  logic [2:0][QB-1:0]     div_q;
  rpg_sign_t              div_sign;

  rpg_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (isq_vld),
    .in_len   (isq_len),
    .in_mag   (isq_side.mag),
    .in_sign  (isq_sign),
    .out_vld  (div_vld),
    .out_q    (div_q),
    .out_sign (div_sign)
  );

  // sign, saturation and output register
  logic                    vld_out_r;
  logic                    deg_out_r;
  logic signed [OUT_W-1:0] dir_r [3];
  logic signed [OUT_W-1:0] dir_nxt [3];
  logic [31:0]             qz [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qz[k] = 32'(div_q[k]);
      if (div_sign.degen) begin
        dir_nxt[k] = '0;
      end else if (div_sign.neg[k]) begin
        dir_nxt[k] = (qz[k] > 32'(SAT_NEG_MAG)) ? OUT_W'(-SAT_NEG_MAG)
                                                : OUT_W'(32'd0 - qz[k]);
      end else begin
        dir_nxt[k] = (qz[k] > 32'(SAT_POS)) ? OUT_W'(SAT_POS) : OUT_W'(qz[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    dir_r     <= dir_nxt;
    deg_out_r <= div_sign.degen;
  end

  assign out_valid      = vld_out_r;
  assign out_dir_x      = dir_r[0];
  assign out_dir_y      = dir_r[1];
  assign out_dir_z      = dir_r[2];
  assign out_degenerate = deg_out_r;

endmodule

// File: sv/rpg_isqrt_pipe.sv
module rpg_isqrt_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [rpg_pkg::SUM_W-1:0]    in_sum,
  input  rpg_pkg::rpg_side_t           in_side,
  output logic                         out_vld,
  output logic [rpg_pkg::LEN_W-1:0]    out_len,
  output rpg_pkg::rpg_side_t           out_side
);
  import rpg_pkg::*;

  localparam int STEPS = SUM_W / 2;

  logic [SUM_W-1:0] v_r    [STEPS];
  logic [SUM_W-1:0] res_r  [STEPS];
  logic             vld_r  [STEPS];
  rpg_side_t        side_r [STEPS];

  // one result bit per stage, digit-by-digit square root
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * (STEPS - 1 - i));
    logic [SUM_W-1:0] v_prev, res_prev, v_nxt, res_nxt;
    logic             vld_prev;
    rpg_side_t        side_prev;
    logic [SUM_W:0]   trial;

    if (i == 0) begin : g_first
      assign v_prev    = in_sum;
      assign res_prev  = '0;
      assign vld_prev  = in_vld;
      assign side_prev = in_side;
    end else begin : g_rest
      assign v_prev    = v_r[i-1];
      assign res_prev  = res_r[i-1];
      assign vld_prev  = vld_r[i-1];
      assign side_prev = side_r[i-1];
    end

    always_comb begin
      trial = {1'b0, res_prev} + {1'b0, STEP_BIT};
      if ({1'b0, v_prev} >= trial) begin
        v_nxt   = v_prev - trial[SUM_W-1:0];
        res_nxt = (res_prev >> 1) + STEP_BIT;
      end else begin
        v_nxt   = v_prev;
        res_nxt = res_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      v_r[i]    <= v_nxt;
      res_r[i]  <= res_nxt;
      side_r[i] <= side_prev;
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_len  = res_r[STEPS-1][LEN_W-1:0];
  assign out_side = side_r[STEPS-1];

endmodule

// File: sv/rpg_div_pipe.sv
module rpg_div_pipe #(
  parameter int FRAC_BITS = rpg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [rpg_pkg::LEN_W-1:0]     in_len,
  input  rpg_pkg::mag_t [2:0]           in_mag,
  input  rpg_pkg::rpg_sign_t            in_sign,
  output logic                          out_vld,
  output logic [2:0][FRAC_BITS+1:0]     out_q,
  output rpg_pkg::rpg_sign_t            out_sign
);
  import rpg_pkg::*;

  // q = (mag*2^(F+1) + len) / (2*len), below 2^QB
  localparam int QB    = FRAC_BITS + 2;
  localparam int NUM_W = MAG_BITS + FRAC_BITS + 2;
  localparam int DIV_W = LEN_W + 1;
  localparam int REM_W = DIV_W + 1;

  logic [DIV_W-1:0] rem_r  [QB][3];
  logic [QB-1:0]    low_r  [QB][3];
  logic [QB-1:0]    q_r    [QB][3];
  logic [DIV_W-1:0] d_r    [QB];
  logic             vld_r  [QB];
  rpg_sign_t        sign_r [QB];

  // numerator set-up feeding the first stage
  logic [DIV_W-1:0] rem_in [3];
  logic [QB-1:0]    low_in [3];
  logic [DIV_W-1:0] d_in;
  logic [NUM_W-1:0] num    [3];

  always_comb begin
    d_in = {in_len, 1'b0};
    for (int k = 0; k < 3; k++) begin
      num[k]    = {in_mag[k], {(FRAC_BITS + 1){1'b0}}} + NUM_W'(in_len);
      rem_in[k] = DIV_W'(num[k] >> QB);
      low_in[k] = num[k][QB-1:0];
    end
  end

  // one quotient bit per stage, restoring
  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [DIV_W-1:0] rem_prev [3];
    logic [QB-1:0]    low_prev [3];
    logic [QB-1:0]    q_prev   [3];
    logic [DIV_W-1:0] d_prev;
    logic             vld_prev;
    rpg_sign_t        sign_prev;
    logic [REM_W-1:0] trial    [3];
    logic [DIV_W-1:0] rem_nxt  [3];
    logic [QB-1:0]    q_nxt    [3];

    if (j == 0) begin : g_first
      assign rem_prev  = rem_in;
      assign low_prev  = low_in;
      assign q_prev    = '{default: '0};
      assign d_prev    = d_in;
      assign vld_prev  = in_vld;
      assign sign_prev = in_sign;
    end else begin : g_rest
      assign rem_prev  = rem_r[j-1];
      assign low_prev  = low_r[j-1];
      assign q_prev    = q_r[j-1];
      assign d_prev    = d_r[j-1];
      assign vld_prev  = vld_r[j-1];
      assign sign_prev = sign_r[j-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem_prev[k], low_prev[k][QB-1]};
        if (trial[k] >= {1'b0, d_prev}) begin
          rem_nxt[k] = DIV_W'(trial[k] - {1'b0, d_prev});
          q_nxt[k]   = {q_prev[k][QB-2:0], 1'b1};
        end else begin
          rem_nxt[k] = trial[k][DIV_W-1:0];
          q_nxt[k]   = {q_prev[k][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[j][k] <= rem_nxt[k];
        low_r[j][k] <= low_prev[k] << 1;
        q_r[j][k]   <= q_nxt[k];
      end
      d_r[j]    <= d_prev;
      sign_r[j] <= sign_prev;
    end
  end

  assign out_vld  = vld_r[QB-1];
  assign out_sign = sign_r[QB-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_q[k] = q_r[QB-1][k];
    end
  end

endmodule

// File: tb/sv/tb_pinhole_camera_ray_generator_top.sv
`timescale 1ns / 100ps

module tb_pinhole_camera_ray_generator_top;
  import rpg_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = FB + 43;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 800;

  typedef struct {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
  } pixel_t;

  typedef struct {
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
    logic signed [OUT_W-1:0] dz;
    logic                    degen;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CB-1:0] in_pixel_x = '0;
  logic [CB-1:0] in_pixel_y = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [VEC_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic out_degenerate;

  // camera registers as the predictor sees them
  logic [CNT_W-1:0] cam_w, cam_h;
  logic [HL_W-1:0]  cam_hx, cam_hy;
  logic [VEC_W-1:0] cam_up, cam_right, cam_off;

  pixel_t pixel_q[$];
  ray_t   ray_q[$];
  int     n_fail = 0;
  int     idle_cycles = 0;
  bit     in_burst = 1'b0;
  int     burst_left = 0;
  bit     hold_sender = 1'b0;

  pinhole_camera_ray_generator_top DUT (.*);

  always #1 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // unit ray through the pixel center, per current camera registers
  function automatic ray_t ray_dir(pixel_t p);
    ray_t r;
    longint w, h, nx, ny, d, off, u, rt;
    longint unsigned mag[3], mx, sum, len, q;
    bit neg[3];
    int s;
    w = (cam_w == 0) ? 1 : longint'(cam_w);
    h = (cam_h == 0) ? 1 : longint'(cam_h);
    nx = 2 * longint'(p.px) + 1 - w;
    ny = 2 * longint'(p.py) + 1 - h;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      off = longint'($signed(cam_off[16*k +: 16]));
      u   = longint'($signed(cam_up[16*k +: 16]));
      rt  = longint'($signed(cam_right[16*k +: 16]));
      d = off * 16384 * w * h + ny * longint'(cam_hy) * u * w
          + nx * longint'(cam_hx) * rt * h;
      neg[k] = d < 0;
      mag[k] = neg[k] ? longint'(-d) : d;
      if (mag[k] > mx) mx = mag[k];
    end
    r = '{0, 0, 0, 1'b0};
    if (mx == 0) begin
      r.degen = 1'b1;
      return r;
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] >>= s;
      sum += mag[k] * mag[k];
    end
    len = root64(sum);
    if (len == 0) len = 1;
    for (int k = 0; k < 3; k++) begin
      logic signed [OUT_W-1:0] v;
      q = ((mag[k] << (FB + 1)) + len) / (2 * len);
      if (neg[k]) v = (q > SAT_NEG_MAG) ? -16'sd32768 : OUT_W'(-longint'(q));
      else v = (q > SAT_POS) ? 16'sd32767 : OUT_W'(q);
      if (k == 0) r.dx = v;
      else if (k == 1) r.dy = v;
      else r.dz = v;
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH:  cam_w = val[CNT_W-1:0];
      REG_HEIGHT: cam_h = val[CNT_W-1:0];
      REG_HALF_X: cam_hx = val[HL_W-1:0];
      REG_HALF_Y: cam_hy = val[HL_W-1:0];
      REG_UP:     cam_up = val;
      REG_RIGHT:  cam_right = val;
      REG_OFFSET: cam_off = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the pipe is empty before touching registers
  task automatic drain();
    wait (pixel_q.size() == 0 && ray_q.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [VEC_W-1:0] rand_vec();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic pixel_t rand_pixel(int wmax, int hmax);
    pixel_t p;
    if ($urandom_range(9) == 0) begin
      p.px = CB'($urandom);
      p.py = CB'($urandom);
    end else begin
      p.px = CB'($urandom_range(wmax - 1));
      p.py = CB'($urandom_range(hmax - 1));
    end
    return p;
  endfunction

  // driver: bursts with random gaps; the accepted word is popped first
  always @(negedge clk) begin
    if (rst_n && start && !busy) void'(pixel_q.pop_front());
    if (!rst_n || hold_sender || pixel_q.size() == 0) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (burst_left == 0) begin
        in_burst = !in_burst;
        burst_left = in_burst ? $urandom_range(1, 40) : $urandom_range(0, 6);
      end
      if (in_burst) begin
        pixel_t p;
        p = pixel_q[0];
        start <= 1'b1;
        in_pixel_x <= p.px;
        in_pixel_y <= p.py;
      end else begin
        start <= 1'b0;
      end
      if (burst_left > 0) burst_left--;
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (rst_n && start && !busy) ray_q.push_back(ray_dir('{in_pixel_x, in_pixel_y}));
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ray_q.size() == 0) begin
        $error("unexpected result word");
        n_fail++;
      end else begin
        ray_t e;
        e = ray_q.pop_front();
        if (out_dir_x !== e.dx) begin
          $error("dir_x exp %0d got %0d", e.dx, out_dir_x); n_fail++;
        end
        if (out_dir_y !== e.dy) begin
          $error("dir_y exp %0d got %0d", e.dy, out_dir_y); n_fail++;
        end
        if (out_dir_z !== e.dz) begin
          $error("dir_z exp %0d got %0d", e.dz, out_dir_z); n_fail++;
        end
        if (out_degenerate !== e.degen) begin
          $error("degenerate exp %0b got %0b", e.degen, out_degenerate); n_fail++;
        end
      end
    end
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int wm, hm;
    cam_w = RST_WIDTH; cam_h = RST_HEIGHT;
    cam_hx = RST_HALF; cam_hy = RST_HALF;
    cam_up = RST_UP; cam_right = RST_RIGHT; cam_off = RST_OFFSET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, center and out-of-range pixels at reset camera
    pixel_q.push_back('{0, 0});
    pixel_q.push_back('{639, 479});
    pixel_q.push_back('{319, 239});
    pixel_q.push_back('{320, 240});
    pixel_q.push_back('{CB'(4095), CB'(4095)});
    pixel_q.push_back('{CB'(4095), 0});
    drain();

    // zero length direction and zero pixel counts
    write_reg(REG_OFFSET, '0);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    pixel_q.push_back('{0, 0});
    pixel_q.push_back('{1, 5});
    drain();

    // extreme registers: counts above 4096, max half lengths, min/max vectors
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'h1FFF);
    write_reg(REG_HALF_X, 16'hFFFF);
    write_reg(REG_HALF_Y, 16'hFFFF);
    write_reg(REG_UP, 48'h8000_8000_8000);
    write_reg(REG_RIGHT, 48'h7FFF_7FFF_7FFF);
    write_reg(REG_OFFSET, 48'h7FFF_8000_7FFF);
    pixel_q.push_back('{0, 0});
    pixel_q.push_back('{CB'(4095), CB'(4095)});
    pixel_q.push_back('{CB'(2047), CB'(4095)});
    pixel_q.push_back('{CB'(4095), 0});
    drain();
    write_reg(REG_HALF_X, 0);
    write_reg(REG_HALF_Y, 0);
    write_reg(REG_OFFSET, 48'h8000_8000_8000);
    pixel_q.push_back('{CB'(1234), CB'(77)});
    drain();

    // random phases with a new camera each time
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_WIDTH, (ph == 0) ? 1 : $urandom_range(1, (ph < 4) ? 64 : 4096));
      write_reg(REG_HEIGHT, (ph == 0) ? 1 : $urandom_range(1, (ph < 4) ? 64 : 4096));
      write_reg(REG_HALF_X, $urandom_range(0, 3) == 0 ? 16'($urandom) : $urandom_range(1, 1024));
      write_reg(REG_HALF_Y, $urandom_range(0, 3) == 0 ? 16'($urandom) : $urandom_range(1, 1024));
      write_reg(REG_UP, rand_vec());
      write_reg(REG_RIGHT, rand_vec());
      write_reg(REG_OFFSET, (ph == 5) ? '0 : rand_vec());
      wm = (cam_w == 0) ? 1 : ((cam_w > 4096) ? 4096 : cam_w);
      hm = (cam_h == 0) ? 1 : ((cam_h > 4096) ? 4096 : cam_h);
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        pixel_q.push_back(rand_pixel(wm, hm));
        // sender holds off once until all results are home
        if (ph == 2 && i == 50) begin
          wait (pixel_q.size() == 0);
          hold_sender = 1'b1;
          wait (ray_q.size() == 0);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
